// ----- src/scll_pkg.sv -----
// ----------------------------------------------------------------------------
// scll_pkg
// Shared types, constants and helpers of the command line lexer core.
// ----------------------------------------------------------------------------
package scll_pkg;

	// Line positions
	localparam int MAX_LINE = 1024;
	localparam int POS_W    = 10;
	localparam int POS_SPAN = (MAX_LINE > (1 << POS_W)) ? (1 << POS_W) : MAX_LINE;
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_SPAN - 1);

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Byte codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_PIPE  = 8'h7C;

	typedef enum logic [1:0] {
		KIND_WORD  = 2'd0,
		KIND_PIPE  = 2'd1,
		KIND_REDIR = 2'd2,
		KIND_END   = 2'd3
	} tok_kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_WORD   = 3'd1,
		MODE_SQUOTE = 3'd2,
		MODE_DQUOTE = 3'd3,
		MODE_REDIR  = 3'd4
	} scan_mode_t;

	typedef struct packed {
		tok_kind_t        kind;
		logic [POS_W-1:0] first;
		logic [POS_W-1:0] last;
		logic             ovf;
	} tok_t;

	// One or two tokens caused by one byte; a single token sits in slot a
	typedef struct packed {
		logic two;
		tok_t a;
		tok_t b;
	} tok_cmd_t;

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_oper(input logic [7:0] c);
		return (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT);
	endfunction

	function automatic tok_t mk_tok(input tok_kind_t kind, input logic [POS_W-1:0] first,
			input logic [POS_W-1:0] last, input logic ovf);
		tok_t t;
		t.kind  = kind;
		t.first = first;
		t.last  = last;
		t.ovf   = ovf;
		return t;
	endfunction

endpackage

// ----- src/scll_front.sv -----
// ----------------------------------------------------------------------------
// scll_front
// Scanner: classifies each byte, tracks the scan mode and builds the tokens
// that the byte closes.
// ----------------------------------------------------------------------------
module scll_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [7:0]        char_code,
	output logic              cmd_push,
	output scll_pkg::tok_cmd_t cmd
);
	import scll_pkg::*;

	scan_mode_t       mode_q, mode_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] tb_q, tb_d;
	logic             gt_q, gt_d;
	logic             ovf_q, ovf_d;

	logic             idle_pass;
	logic [7:0]       want;
	logic [POS_W-1:0] prev_end;
	logic             first_v, second_v;
	tok_t             first_tok, second_tok;

	assign want     = gt_q ? CH_GT : CH_LT;
	assign prev_end = ovf_q ? POS_LIMIT : ((pos_q != '0) ? (pos_q - POS_W'(1)) : '0);

	// Byte falls through to the between-tokens handling
	always_comb begin
		idle_pass = 1'b0;
		if (char_code != CH_NUL) begin
			unique case (mode_q)
				MODE_REDIR:  idle_pass = (char_code != want);
				MODE_WORD:   idle_pass = is_oper(char_code);
				MODE_SQUOTE,
				MODE_DQUOTE: idle_pass = 1'b0;
				default:     idle_pass = 1'b1;
			endcase
		end
	end

	// Next state
	always_comb begin
		mode_d = mode_q;
		tb_d   = tb_q;
		gt_d   = gt_q;
		pos_d  = pos_q;
		ovf_d  = ovf_q;
		if (char_code == CH_NUL) begin
			mode_d = MODE_IDLE;
			tb_d   = '0;
			gt_d   = 1'b0;
			pos_d  = '0;
			ovf_d  = 1'b0;
		end else begin
			unique case (mode_q)
				MODE_REDIR: mode_d = MODE_IDLE;
				MODE_SQUOTE: begin
					if (char_code == CH_SQ)
						mode_d = MODE_WORD;
				end
				MODE_DQUOTE: begin
					if (char_code == CH_DQ)
						mode_d = MODE_WORD;
				end
				MODE_WORD: begin
					if (is_sep(char_code) || is_oper(char_code))
						mode_d = MODE_IDLE;
					else if (char_code == CH_SQ)
						mode_d = MODE_SQUOTE;
					else if (char_code == CH_DQ)
						mode_d = MODE_DQUOTE;
				end
				default: mode_d = MODE_IDLE;
			endcase
			if (idle_pass && !is_sep(char_code) && (char_code != CH_PIPE)) begin
				tb_d = pos_q;
				if ((char_code == CH_LT) || (char_code == CH_GT)) begin
					gt_d   = (char_code == CH_GT);
					mode_d = MODE_REDIR;
				end else if (char_code == CH_SQ) begin
					mode_d = MODE_SQUOTE;
				end else if (char_code == CH_DQ) begin
					mode_d = MODE_DQUOTE;
				end else begin
					mode_d = MODE_WORD;
				end
			end
			// Saturate at the last position and flag the line
			if (pos_q < POS_LIMIT)
				pos_d = pos_q + POS_W'(1);
			else
				ovf_d = 1'b1;
		end
	end

	// Tokens closed by this byte
	always_comb begin
		first_v    = 1'b0;
		second_v   = 1'b0;
		first_tok  = mk_tok(KIND_WORD, tb_q, prev_end, ovf_q);
		second_tok = mk_tok(KIND_PIPE, pos_q, pos_q, ovf_q);
		if (char_code == CH_NUL) begin
			unique case (mode_q)
				MODE_WORD, MODE_SQUOTE, MODE_DQUOTE: first_v = 1'b1;
				MODE_REDIR: begin
					first_v   = 1'b1;
					first_tok = mk_tok(KIND_REDIR, tb_q, prev_end, ovf_q);
				end
				default: first_v = 1'b0;
			endcase
			second_v   = 1'b1;
			second_tok = mk_tok(KIND_END, pos_q, pos_q, ovf_q);
		end else begin
			unique case (mode_q)
				MODE_REDIR: begin
					first_v   = 1'b1;
					first_tok = mk_tok(KIND_REDIR, tb_q,
						(char_code == want) ? pos_q : prev_end, ovf_q);
				end
				MODE_WORD: first_v = is_sep(char_code) || is_oper(char_code);
				default:   first_v = 1'b0;
			endcase
			second_v = idle_pass && (char_code == CH_PIPE);
		end
	end

	always_comb begin
		cmd_push = in_fire && (first_v || second_v);
		cmd.two  = first_v && second_v;
		cmd.a    = first_v ? first_tok : second_tok;
		cmd.b    = second_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q  <= '0;
			tb_q   <= '0;
			gt_q   <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (in_fire) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			tb_q   <= tb_d;
			gt_q   <= gt_d;
			ovf_q  <= ovf_d;
		end
	end

endmodule

// ----- src/scll_queue.sv -----
// ----------------------------------------------------------------------------
// scll_queue
// Short queue of token commands between the scanner and the result sequencer.
// ----------------------------------------------------------------------------
module scll_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_cmd,
	input  scll_pkg::tok_cmd_t push_data,
	input  logic              pop_cmd,
	output logic              q_full,
	output logic              q_empty,
	output scll_pkg::tok_cmd_t head
);
	import scll_pkg::*;

	tok_cmd_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign q_full  = (cnt_q == QCNT_W'(QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_push = push_cmd && !q_full;
	assign do_pop  = pop_cmd && !q_empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

// ----- src/scll_back.sv -----
// ----------------------------------------------------------------------------
// scll_back
// Result sequencer: presents the tokens of the head command one per
// transaction and releases the command after its last token.
// ----------------------------------------------------------------------------
module scll_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  scll_pkg::tok_cmd_t      head,
	input  logic                    q_empty,
	input  logic                    pop,
	output logic                    pop_cmd,
	output logic                    empty,
	output logic [1:0]              token_kind,
	output logic [scll_pkg::POS_W-1:0] token_start,
	output logic [scll_pkg::POS_W-1:0] token_end,
	output logic                    line_overflow,
	output logic                    last_of_run
);
	import scll_pkg::*;

	logic idx_q;
	tok_t cur;
	logic out_fire;

	assign empty         = q_empty;
	assign out_fire      = pop && !q_empty;
	assign cur           = idx_q ? head.b : head.a;
	assign last_of_run   = !head.two || idx_q;
	assign pop_cmd       = out_fire && last_of_run;
	assign token_kind    = cur.kind;
	assign token_start   = cur.first;
	assign token_end     = cur.last;
	assign line_overflow = cur.ovf;

	// Advance to the second token, or back to the first once the command drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= 1'b0;
		else if (out_fire)
			idx_q <= !last_of_run;
	end

endmodule

// ----- src/shell_command_line_lexer_core.sv -----
// ----------------------------------------------------------------------------
// shell_command_line_lexer_core
// Command line lexer: splits a byte stream into word, pipe and redirect
// tokens with their positions, and marks the end of every line.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------
//   input    | in        | push / full          | char_code
//   result   | out       | pop / empty          | token_kind, token_start,
//            |           |                      | token_end, line_overflow,
//            |           |                      | last_of_run
//
// One byte is taken per cycle while the four-entry command queue has room;
// a byte yields zero, one or two results, and results leave one per cycle
// while pop is held. The result side is the limit: two-result bytes yield
// results faster than they leave. A result reaches the ports from the queue
// behind earlier results. Reset clears the scan state and empties the queue;
// either side may stall at any time without losing a transaction.
// ----------------------------------------------------------------------------
module shell_command_line_lexer_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [7:0]              char_code,
	input  logic                    pop,
	output logic                    empty,
	output logic [1:0]              token_kind,
	output logic [scll_pkg::POS_W-1:0] token_start,
	output logic [scll_pkg::POS_W-1:0] token_end,
	output logic                    line_overflow,
	output logic                    last_of_run
);
	import scll_pkg::*;

	logic     in_fire;
	logic     q_push, q_pop, q_full, q_empty;
	tok_cmd_t q_data, q_head;

	assign full    = q_full;
	assign in_fire = push && !q_full;

	scll_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.char_code (char_code),
		.cmd_push  (q_push),
		.cmd       (q_data)
	);

	scll_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cmd  (q_push),
		.push_data (q_data),
		.pop_cmd   (q_pop),
		.q_full    (q_full),
		.q_empty   (q_empty),
		.head      (q_head)
	);

	scll_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.q_empty       (q_empty),
		.pop           (pop),
		.pop_cmd       (q_pop),
		.empty         (empty),
		.token_kind    (token_kind),
		.token_start   (token_start),
		.token_end     (token_end),
		.line_overflow (line_overflow),
		.last_of_run   (last_of_run)
	);

	// A line end always produces at least the end marker
	a_nul_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (char_code == CH_NUL)) |-> q_push)
		else $error("line end produced no result");

	// The scanner only writes the queue for an accepted byte
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> in_fire)
		else $error("command written without an accepted byte");

	// A taken first token of a pair leaves its partner waiting
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_of_run) |=> (!empty && last_of_run))
		else $error("second token of a pair missing");

	// An end marker always closes a run
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (token_kind == KIND_END)) |-> last_of_run)
		else $error("end marker not last of its run");

endmodule
